>>> design/port_table_allocate_find_unit_defines.svh
// assertion macros of the port table rtl
`ifndef PORT_TABLE_ALLOCATE_FIND_UNIT_DEFINES_SVH
`define PORT_TABLE_ALLOCATE_FIND_UNIT_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define PTAF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define PTAF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ptaf_pkg.sv
// shared types, constants and codes of the port table
`default_nettype none

package ptaf_pkg;

    // default sizes
    localparam int NUM_PORTS_DEF  = 32;
    localparam int OWNER_BITS_DEF = 8;

    // fixed field widths
    localparam int PORT_ID_W     = 32;
    localparam int OWNER_IN_W    = 8;
    localparam int OWNER_EXT_W   = 16;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_INDEX_W = 5;

    // command codes
    localparam logic CMD_ALLOCATE = 1'b0;
    localparam logic CMD_FIND     = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    // scan token passed from cell to cell
    typedef struct packed {
        logic valid;
        logic hit;
        logic free;
    } scan_t;

endpackage

`default_nettype wire

>>> design/port_table_allocate_find_unit.sv
// port table top level: request capture, cell chain, result and response register
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   request  | req_valid, req_stall | cmd, port_id, owner_thread
//   response | rsp_valid, rsp_stall | status, entry_index
//
// an item's scan token walks the chain of NUM_PORTS entry cells at one cell per cycle.
// one item is in work at a time; req_stall is high from accept until its result
// has moved into the response register, so a held response does not block the next item.
// reset clears every valid mark at once; entry contents are not reset.
// allocate writes the chosen entry in the cycle the token leaves the last cell.
`default_nettype none

`include "port_table_allocate_find_unit_defines.svh"

module port_table_allocate_find_unit #(
    parameter int NUM_PORTS  = ptaf_pkg::NUM_PORTS_DEF,
    parameter int OWNER_BITS = ptaf_pkg::OWNER_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 req_valid,
    output logic                                req_stall,
    input  wire                                 cmd,
    input  wire [ptaf_pkg::PORT_ID_W-1:0]       port_id,
    input  wire [ptaf_pkg::OWNER_IN_W-1:0]      owner_thread,
    output logic                                rsp_valid,
    input  wire                                 rsp_stall,
    output logic [ptaf_pkg::STATUS_W-1:0]       status,
    output logic [ptaf_pkg::ENTRY_INDEX_W-1:0]  entry_index
);

    localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int EIW   = ptaf_pkg::ENTRY_INDEX_W;

    logic                              req_accept;
    logic                              busy_reg;
    logic                              busy_next;
    logic                              start_reg;
    logic                              cmd_reg;
    logic [ptaf_pkg::PORT_ID_W-1:0]    ident_reg;
    logic [OWNER_BITS-1:0]             owner_reg;
    logic [ptaf_pkg::OWNER_EXT_W-1:0]  owner_ext;

    ptaf_pkg::scan_t                   tok_chain     [0:NUM_PORTS];
    logic [IDX_W-1:0]                  hit_idx_chain [0:NUM_PORTS];
    logic [IDX_W-1:0]                  free_idx_chain[0:NUM_PORTS];

    ptaf_pkg::scan_t                   tok_last;
    logic                              wr_en;
    logic [ptaf_pkg::STATUS_W-1:0]     res_status;
    logic [IDX_W-1:0]                  res_idx;
    logic [IDX_W+EIW-1:0]              res_idx_ext;

    logic                              res_valid_reg;
    logic [ptaf_pkg::STATUS_W-1:0]     res_status_reg;
    logic [EIW-1:0]                    res_index_reg;
    logic                              res_move;
    logic                              rsp_valid_reg;
    logic [ptaf_pkg::STATUS_W-1:0]     rsp_status_reg;
    logic [EIW-1:0]                    rsp_index_reg;

    // request handshake
    assign req_accept = req_valid && !busy_reg;
    assign req_stall  = busy_reg;
    assign owner_ext  = {{(ptaf_pkg::OWNER_EXT_W - ptaf_pkg::OWNER_IN_W){1'b0}}, owner_thread};

    // result leaves the holding stage when the response register is free
    assign res_move  = res_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign busy_next = req_accept ? 1'b1 : (res_move ? 1'b0 : busy_reg);

    // request capture
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            cmd_reg   <= cmd;
            ident_reg <= port_id;
            owner_reg <= owner_ext[OWNER_BITS-1:0];
        end
    end

    // chain head: token launched the cycle after accept
    assign tok_chain[0]      = '{valid: start_reg, hit: 1'b0, free: 1'b0};
    assign hit_idx_chain[0]  = '0;
    assign free_idx_chain[0] = '0;

    // row of entry cells
    for (genvar i = 0; i < NUM_PORTS; i++)
    begin : g_cell
        ptaf_cell #(
            .IDX_W      (IDX_W),
            .OWNER_BITS (OWNER_BITS),
            .CELL_IDX   (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .tok_in       (tok_chain[i]),
            .hit_idx_in   (hit_idx_chain[i]),
            .free_idx_in  (free_idx_chain[i]),
            .req_ident    (ident_reg),
            .req_owner    (owner_reg),
            .wr_en        (wr_en),
            .wr_idx       (free_idx_chain[NUM_PORTS]),
            .tok_out      (tok_chain[i+1]),
            .hit_idx_out  (hit_idx_chain[i+1]),
            .free_idx_out (free_idx_chain[i+1])
        );
    end

    assign tok_last = tok_chain[NUM_PORTS];

    // decide the outcome once the token has passed every cell
    always_comb
    begin
        wr_en      = 1'b0;
        res_status = ptaf_pkg::ST_OK;
        res_idx    = '0;
        if (cmd_reg == ptaf_pkg::CMD_FIND)
        begin
            priority if (tok_last.hit)
            begin
                res_idx = hit_idx_chain[NUM_PORTS];
            end
            else
            begin
                res_status = ptaf_pkg::ST_MISSING;
            end
        end
        else
        begin
            priority if (tok_last.hit)
            begin
                res_status = ptaf_pkg::ST_DUP;
            end
            else if (tok_last.free)
            begin
                res_idx = free_idx_chain[NUM_PORTS];
                wr_en   = tok_last.valid;
            end
            else
            begin
                res_status = ptaf_pkg::ST_FULL;
            end
        end
    end

    assign res_idx_ext = {{EIW{1'b0}}, res_idx};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            start_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            start_reg <= req_accept;
            if (tok_last.valid)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_move)
            begin
                res_valid_reg <= 1'b0;
            end
            if (res_move)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        if (tok_last.valid)
        begin
            res_status_reg <= res_status;
            res_index_reg  <= res_idx_ext[EIW-1:0];
        end
        if (res_move)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_index_reg  <= res_index_reg;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign entry_index = rsp_index_reg;

    // checks
    `PTAF_ASSERT_IMPL(a_err_index_zero, clk, rst_n, rsp_valid && (status != ptaf_pkg::ST_OK), entry_index == '0, "nonzero index on error status")
    `PTAF_ASSERT_IMPL(a_scan_while_busy, clk, rst_n, tok_last.valid || start_reg || res_valid_reg, busy_reg, "scan activity while not busy")
    `PTAF_ASSERT_NEXT(a_accept_launch, clk, rst_n, req_accept, start_reg && busy_reg, "accepted item did not launch a scan")
    `PTAF_ASSERT_IMPL(a_one_stage, clk, rst_n, 1'b1, $onehot0({start_reg, tok_last.valid, res_valid_reg}), "more than one scan stage active")

endmodule

`default_nettype wire

>>> design/ptaf_cell.sv
// one table entry plus its stage of the scan chain
`default_nettype none

module ptaf_cell #(
    parameter int IDX_W      = 5,
    parameter int OWNER_BITS = 8,
    parameter int CELL_IDX   = 0
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  ptaf_pkg::scan_t                tok_in,
    input  wire [IDX_W-1:0]                hit_idx_in,
    input  wire [IDX_W-1:0]                free_idx_in,
    input  wire [ptaf_pkg::PORT_ID_W-1:0]  req_ident,
    input  wire [OWNER_BITS-1:0]           req_owner,
    input  wire                            wr_en,
    input  wire [IDX_W-1:0]                wr_idx,
    output ptaf_pkg::scan_t                tok_out,
    output logic [IDX_W-1:0]               hit_idx_out,
    output logic [IDX_W-1:0]               free_idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                           valid_reg;
    logic [OWNER_BITS-1:0]          owner_reg;
    logic [ptaf_pkg::PORT_ID_W-1:0] ident_reg;
    ptaf_pkg::scan_t                tok_reg;
    ptaf_pkg::scan_t                tok_next;
    logic [IDX_W-1:0]               hit_idx_reg;
    logic [IDX_W-1:0]               hit_idx_next;
    logic [IDX_W-1:0]               free_idx_reg;
    logic [IDX_W-1:0]               free_idx_next;
    logic                           my_hit;
    logic                           my_free;
    logic                           my_wr;

    // entry compare
    assign my_hit  = valid_reg && (owner_reg == req_owner) && (ident_reg == req_ident);
    assign my_free = !valid_reg;
    assign my_wr   = wr_en && (wr_idx == MY_IDX);

    // keep the lowest hit and free index seen so far
    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.hit   = tok_in.hit  || my_hit;
        tok_next.free  = tok_in.free || my_free;
        hit_idx_next   = tok_in.hit  ? hit_idx_in  : MY_IDX;
        free_idx_next  = tok_in.free ? free_idx_in : MY_IDX;
    end

    // valid mark and token control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (my_wr)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    // entry contents and token indexes
    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        if (my_wr)
        begin
            owner_reg <= req_owner;
            ident_reg <= req_ident;
        end
    end

    assign tok_out      = tok_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench of the port table: allocate and find traffic against a local table
`default_nettype none

module tb_top;

    localparam int NUM_PORTS   = 32;
    localparam int OWNER_BITS  = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = NUM_PORTS + 10;
    localparam logic [ptaf_pkg::OWNER_IN_W-1:0] OWNER_MASK =
        ptaf_pkg::OWNER_IN_W'((1 << OWNER_BITS) - 1);

    typedef struct packed {
        logic [ptaf_pkg::STATUS_W-1:0]      status;
        logic [ptaf_pkg::ENTRY_INDEX_W-1:0] index;
    } port_result_t;

    // clock, reset and block ports; the driven ones are known from time zero
    logic                               clk          = 1'b0;
    logic                               rst_n        = 1'b0;
    logic                               req_valid    = 1'b0;
    logic                               req_stall;
    logic                               cmd          = ptaf_pkg::CMD_ALLOCATE;
    logic [ptaf_pkg::PORT_ID_W-1:0]     port_id      = '0;
    logic [ptaf_pkg::OWNER_IN_W-1:0]    owner_thread = '0;
    logic                               rsp_valid;
    logic                               rsp_stall    = 1'b0;
    logic [ptaf_pkg::STATUS_W-1:0]      status;
    logic [ptaf_pkg::ENTRY_INDEX_W-1:0] entry_index;

    // local copy of the port table
    logic                            slot_used  [NUM_PORTS];
    logic [ptaf_pkg::OWNER_IN_W-1:0] slot_owner [NUM_PORTS];
    logic [ptaf_pkg::PORT_ID_W-1:0]  slot_ident [NUM_PORTS];
    int                              slot_count;

    port_result_t pending_results[$];
    int           error_count   = 0;
    int           items_sent    = 0;
    int           status_seen[4] = '{0, 0, 0, 0};
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           burst_seq     = 0;

    port_table_allocate_find_unit #(
        .NUM_PORTS  (NUM_PORTS),
        .OWNER_BITS (OWNER_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .cmd          (cmd),
        .port_id      (port_id),
        .owner_thread (owner_thread),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .entry_index  (entry_index)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // table update and expected result of one accepted item
    function automatic port_result_t apply_port_request(
        input logic                            c,
        input logic [ptaf_pkg::PORT_ID_W-1:0]  id,
        input logic [ptaf_pkg::OWNER_IN_W-1:0] own);
        port_result_t r;
        logic [ptaf_pkg::OWNER_IN_W-1:0] key;
        int hit;
        int open_slot;
        key = own & OWNER_MASK;
        hit = -1;
        open_slot = -1;
        for (int i = NUM_PORTS - 1; i >= 0; i--)
        begin
            if (slot_used[i] && slot_owner[i] == key && slot_ident[i] == id)
                hit = i;
            if (!slot_used[i])
                open_slot = i;
        end
        r.index = '0;
        if (c == ptaf_pkg::CMD_ALLOCATE)
        begin
            if (hit >= 0)
                r.status = ptaf_pkg::ST_DUP;
            else if (open_slot < 0)
                r.status = ptaf_pkg::ST_FULL;
            else
            begin
                slot_used[open_slot]  = 1'b1;
                slot_owner[open_slot] = key;
                slot_ident[open_slot] = id;
                slot_count++;
                r.status = ptaf_pkg::ST_OK;
                r.index  = ptaf_pkg::ENTRY_INDEX_W'(open_slot);
            end
        end
        else if (hit >= 0)
        begin
            r.status = ptaf_pkg::ST_OK;
            r.index  = ptaf_pkg::ENTRY_INDEX_W'(hit);
        end
        else
            r.status = ptaf_pkg::ST_MISSING;
        return r;
    endfunction

    // random owner number over the full input range
    function automatic logic [ptaf_pkg::OWNER_IN_W-1:0] rand_owner();
        return ptaf_pkg::OWNER_IN_W'($urandom_range(255));
    endfunction

    // offer one item, wait for its accept, record what it should produce
    task automatic send_port_item(input logic c, input logic [ptaf_pkg::PORT_ID_W-1:0] id,
                                  input logic [ptaf_pkg::OWNER_IN_W-1:0] own);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_valid    <= 1'b1;
        cmd          <= c;
        port_id      <= id;
        owner_thread <= own;
        do @(posedge clk); while (req_stall);
        pending_results.push_back(apply_port_request(c, id, own));
        items_sent++;
    endtask

    // drop valid and let one edge pass before anything else is driven
    task automatic stop_sending();
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // response stall: random idling plus a long hold-off on request
    always @(posedge clk)
    begin
        static int burst_seen = 0;
        static int hold_left  = 0;
        if (burst_seq != burst_seen)
        begin
            burst_seen = burst_seq;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        port_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, status %0d index %0d",
                         $time, status, entry_index);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                status_seen[want.status]++;
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, status);
                    error_count++;
                end
                if (entry_index !== want.index)
                begin
                    $display("%0t: entry_index mismatch, expected %0d actual %0d",
                             $time, want.index, entry_index);
                    error_count++;
                end
            end
        end
    end

    // extremes, duplicates with room left, near misses on an almost empty table
    task automatic test_directed_cases();
        send_port_item(ptaf_pkg::CMD_FIND,     32'h0000_0000, 8'h00);
        send_port_item(ptaf_pkg::CMD_FIND,     32'hFFFF_FFFF, 8'hFF);
        send_port_item(ptaf_pkg::CMD_ALLOCATE, 32'h0000_0000, 8'h00);
        send_port_item(ptaf_pkg::CMD_ALLOCATE, 32'hFFFF_FFFF, 8'hFF);
        send_port_item(ptaf_pkg::CMD_ALLOCATE, 32'h0000_0000, 8'h00);
        send_port_item(ptaf_pkg::CMD_ALLOCATE, 32'hFFFF_FFFF, 8'hFF);
        send_port_item(ptaf_pkg::CMD_FIND,     32'h0000_0000, 8'h00);
        send_port_item(ptaf_pkg::CMD_FIND,     32'hFFFF_FFFF, 8'hFF);
        send_port_item(ptaf_pkg::CMD_FIND,     32'hFFFF_FFFF, 8'h00);
        send_port_item(ptaf_pkg::CMD_FIND,     32'h0000_0000, 8'hFF);
        send_port_item(ptaf_pkg::CMD_ALLOCATE, 32'hFFFF_FFFF, 8'h00);
        send_port_item(ptaf_pkg::CMD_ALLOCATE, 32'h0000_0000, 8'hFF);
        send_port_item(ptaf_pkg::CMD_FIND,     32'hFFFF_FFFF, 8'h00);
        send_port_item(ptaf_pkg::CMD_FIND,     32'h0000_0000, 8'hFF);
        send_port_item(ptaf_pkg::CMD_ALLOCATE, 32'h8000_0000, 8'h80);
        send_port_item(ptaf_pkg::CMD_FIND,     32'h8000_0001, 8'h80);
        send_port_item(ptaf_pkg::CMD_FIND,     32'h8000_0000, 8'h81);
        send_port_item(ptaf_pkg::CMD_FIND,     32'h8000_0000, 8'h80);
        send_port_item(ptaf_pkg::CMD_ALLOCATE, 32'h5555_5555, 8'hAA);
        send_port_item(ptaf_pkg::CMD_FIND,     32'hAAAA_AAAA, 8'h55);
        send_port_item(ptaf_pkg::CMD_FIND,     32'h5555_5555, 8'hAA);
        stop_sending();
    endtask

    // mostly hits, duplicates and near misses on stored ports, slow fill of the table
    task automatic test_random_phase(input int n_items, input int send_pct, input int recv_pct);
        int pick;
        int slot;
        logic [ptaf_pkg::PORT_ID_W-1:0]  id;
        logic [ptaf_pkg::OWNER_IN_W-1:0] own;
        logic c;
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        repeat (n_items)
        begin
            pick = $urandom_range(99);
            id   = $urandom();
            own  = rand_owner();
            c    = 1'($urandom_range(1));
            if (slot_count > 0 && pick < 85)
            begin
                slot = $urandom_range(slot_count - 1);
                id   = slot_ident[slot];
                own  = slot_owner[slot];
                if (pick < 45)
                    c = ptaf_pkg::CMD_FIND;
                else if (pick < 65)
                    c = ptaf_pkg::CMD_ALLOCATE;
                else
                begin
                    // one bit off in either field
                    if ($urandom_range(1))
                        id = id ^ (32'h1 << $urandom_range(31));
                    else
                        own = own ^ (8'h1 << $urandom_range(7));
                    c = ($urandom_range(99) < 8) ? ptaf_pkg::CMD_ALLOCATE : ptaf_pkg::CMD_FIND;
                end
            end
            else if (pick < 88)
                c = ptaf_pkg::CMD_ALLOCATE;
            else if (pick < 95)
                c = ptaf_pkg::CMD_FIND;
            send_port_item(c, id, own);
        end
        stop_sending();
    endtask

    // fill every entry, go past full, duplicate on a full table, then find each entry
    task automatic test_full_table();
        send_idle_pct = 10;
        recv_idle_pct <= 30;
        while (slot_count < NUM_PORTS)
            send_port_item(ptaf_pkg::CMD_ALLOCATE, $urandom(), rand_owner());
        send_port_item(ptaf_pkg::CMD_ALLOCATE, $urandom(), rand_owner());
        send_port_item(ptaf_pkg::CMD_ALLOCATE, 32'hFFFF_FFFE, 8'hFE);
        send_port_item(ptaf_pkg::CMD_ALLOCATE, slot_ident[NUM_PORTS-1], slot_owner[NUM_PORTS-1]);
        send_port_item(ptaf_pkg::CMD_ALLOCATE, slot_ident[0], slot_owner[0]);
        for (int i = 0; i < NUM_PORTS; i++)
            send_port_item(ptaf_pkg::CMD_FIND, slot_ident[i], slot_owner[i]);
        send_port_item(ptaf_pkg::CMD_FIND, $urandom(), rand_owner());
        stop_sending();
    endtask

    // receiver holds off while items keep coming, so the block backs up to its input
    task automatic test_back_pressure();
        int slot;
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        burst_seq <= burst_seq + 1;
        repeat (10)
        begin
            slot = $urandom_range(slot_count - 1);
            if ($urandom_range(1))
                send_port_item(ptaf_pkg::CMD_FIND, slot_ident[slot], slot_owner[slot]);
            else
                send_port_item(ptaf_pkg::CMD_ALLOCATE, $urandom(), rand_owner());
        end
        stop_sending();
    endtask

    // test sequence
    initial
    begin
        for (int i = 0; i < NUM_PORTS; i++)
        begin
            slot_used[i]  = 1'b0;
            slot_owner[i] = '0;
            slot_ident[i] = '0;
        end
        slot_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 29;
        recv_idle_pct <= 67;
        test_directed_cases();
        test_random_phase(450, 29, 67);
        test_random_phase(450, 67, 29);
        test_random_phase(450, 0, 0);
        test_full_table();
        wait_for_drain();
        test_back_pressure();
        wait_for_drain();

        $display("covered %0d items: %0d ok, %0d duplicate, %0d full, %0d not found",
                 items_sent, status_seen[ptaf_pkg::ST_OK], status_seen[ptaf_pkg::ST_DUP],
                 status_seen[ptaf_pkg::ST_FULL], status_seen[ptaf_pkg::ST_MISSING]);
        $display("three idling mixes, a filled table and a %0d-cycle response hold-off",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("[port_table_allocate_find_unit] OK");
        else
            $display("[port_table_allocate_find_unit] ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("timeout, %0d results still expected", pending_results.size());
        $display("[port_table_allocate_find_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
